[rtl/pose_history_interpolator_macros.svh]
// Assertion macros for the pose history interpolator.
// Used by the top level; expects clk and rst_n in scope.
`ifndef POSE_HISTORY_INTERPOLATOR_MACROS_SVH
`define POSE_HISTORY_INTERPOLATOR_MACROS_SVH

// same-cycle implication
`define PHI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PHI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/phi_pkg.sv]
// Shared types and constants for the pose history interpolator.
// No dependencies.
package phi_pkg;

  localparam int unsigned POS_W   = 24;
  localparam int unsigned ANG_W   = 16;
  localparam int unsigned TIME_W  = 40;
  localparam int unsigned WIN_W   = 20;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned ALPHA_W = 17;

  localparam logic [WIN_W-1:0] WINDOW_RST = 20'd5000;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
    logic signed [ANG_W-1:0]  hdg;
    logic        [TIME_W-1:0] stamp;
  } entry_t;

  typedef enum logic [1:0] {
    SRC_INTERP = 2'd0,
    SRC_OLDEST = 2'd1,
    SRC_NEWEST = 2'd2,
    SRC_EMPTY  = 2'd3
  } src_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PWR,
    ST_PCHK,
    ST_PCMP,
    ST_QA,
    ST_QB,
    ST_QC,
    ST_SCAN,
    ST_DIV,
    ST_MUL
  } state_t;

endpackage

[rtl/pose_history_interpolator.sv]
// Channel   | ports                                          | handshake
// input     | in_opcode in_pos_x in_pos_y in_heading in_time_ms | start & !busy
// result    | out_x out_y out_heading out_used_time out_source | out_valid, 1 cycle
// config    | cfg_window_ms                                  | cfg_we
//
// Push: busy through the write and count-check states; with more than two entries
// left a compare state follows, and each dropped oldest entry adds a read and a
// compare. Query: an empty history ends after the count check; a clamped result
// after the oldest and newest entries are read; interpolation adds a scan of the
// entries (one memory read port), the serial divider and the shared multiplier.
// The result strobes in the same cycle that busy drops; results cannot be stalled.
// Synchronous active-low reset empties the history, window_ms returns to 5000.
// Top level of the pose history interpolator.
// Depends on phi_pkg, phi_mem, phi_div and pose_history_interpolator_macros.svh.
`include "pose_history_interpolator_macros.svh"

module pose_history_interpolator #(
  parameter int unsigned HISTORY_DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_opcode,
  input  logic signed [phi_pkg::POS_W-1:0]   in_pos_x,
  input  logic signed [phi_pkg::POS_W-1:0]   in_pos_y,
  input  logic signed [phi_pkg::ANG_W-1:0]   in_heading,
  input  logic        [phi_pkg::TIME_W-1:0]  in_time_ms,
  input  logic                               cfg_we,
  input  logic        [phi_pkg::WIN_W-1:0]   cfg_window_ms,
  output logic                               out_valid,
  output logic signed [phi_pkg::POS_W-1:0]   out_x,
  output logic signed [phi_pkg::POS_W-1:0]   out_y,
  output logic signed [phi_pkg::ANG_W-1:0]   out_heading,
  output logic        [phi_pkg::TIME_W-1:0]  out_used_time,
  output logic        [1:0]                  out_source
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam logic [CW:0] DEPTH_W = (CW + 1)'(HISTORY_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);
  localparam int unsigned SW = phi_pkg::TIME_W + 2;
  localparam int unsigned MW = phi_pkg::ALPHA_W + 1 + phi_pkg::POS_W + 1;

  function automatic logic [AW-1:0] slot_f(input logic [AW-1:0] base,
                                           input logic [CW-1:0] k);
    logic [CW:0] s;
    s = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, k};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[AW-1:0];
  endfunction

  phi_pkg::state_t state_r, state_nxt;

  logic [phi_pkg::WIN_W-1:0]   win_r;
  logic [AW-1:0]               oldest_r;
  logic [CW-1:0]               cnt_r;
  logic [CW-1:0]               idx_r;
  logic                        rv_r;
  logic [1:0]                  mk_r;
  phi_pkg::entry_t             in_r;
  phi_pkg::entry_t             a_r;
  phi_pkg::entry_t             b_r;
  phi_pkg::entry_t             prev_r;
  phi_pkg::entry_t             q_r;
  logic [phi_pkg::ALPHA_W-1:0] alpha_r;
  logic signed [MW-1:0]        prod_r;

  logic                        out_valid_r;
  logic signed [phi_pkg::POS_W-1:0]  out_x_r;
  logic signed [phi_pkg::POS_W-1:0]  out_y_r;
  logic signed [phi_pkg::ANG_W-1:0]  out_h_r;
  logic [phi_pkg::TIME_W-1:0]        out_t_r;
  phi_pkg::src_t                     out_src_r;

  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [AW-1:0]               mem_raddr;
  phi_pkg::entry_t             rd;

  logic                        full;
  logic signed [SW-1:0]        span;
  logic                        drop;
  logic                        hit;
  logic                        div_start;
  logic                        div_done;
  logic [phi_pkg::ALPHA_W-1:0] div_quot;
  logic [phi_pkg::ANG_W-1:0]   dh;
  logic signed [phi_pkg::POS_W:0] mul_op;

  assign full = (cnt_r == DEPTH_C);
  assign span = $signed({2'b00, in_r.stamp}) - $signed({2'b00, rd.stamp});
  assign drop = span > $signed({{(SW - phi_pkg::WIN_W){1'b0}}, win_r});
  assign hit  = rv_r && (in_r.stamp <= rd.stamp);
  assign dh   = q_r.hdg - prev_r.hdg;

  always_comb begin
    case (mk_r)
      2'd0:    mul_op = {q_r.x[phi_pkg::POS_W-1], q_r.x} -
                        {prev_r.x[phi_pkg::POS_W-1], prev_r.x};
      2'd1:    mul_op = {q_r.y[phi_pkg::POS_W-1], q_r.y} -
                        {prev_r.y[phi_pkg::POS_W-1], prev_r.y};
      default: mul_op = {{(phi_pkg::POS_W + 1 - phi_pkg::ANG_W){dh[phi_pkg::ANG_W-1]}},
                         dh};
    endcase
  end

  phi_mem #(
    .DEPTH (HISTORY_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_r),
    .raddr (mem_raddr),
    .rdata (rd)
  );

  phi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (in_r.stamp - prev_r.stamp),
    .den   (rd.stamp - prev_r.stamp),
    .done  (div_done),
    .quot  (div_quot)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      phi_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = (in_opcode == phi_pkg::OP_PUSH) ? phi_pkg::ST_PWR : phi_pkg::ST_QA;
        end
      end
      phi_pkg::ST_PWR:  state_nxt = phi_pkg::ST_PCHK;
      phi_pkg::ST_PCHK: state_nxt = (cnt_r > CW'(2)) ? phi_pkg::ST_PCMP : phi_pkg::ST_IDLE;
      phi_pkg::ST_PCMP: state_nxt = drop ? phi_pkg::ST_PCHK : phi_pkg::ST_IDLE;
      phi_pkg::ST_QA:   state_nxt = (cnt_r == '0) ? phi_pkg::ST_IDLE : phi_pkg::ST_QB;
      phi_pkg::ST_QB:   state_nxt = phi_pkg::ST_QC;
      phi_pkg::ST_QC: begin
        if (in_r.stamp <= a_r.stamp || in_r.stamp >= rd.stamp) begin
          state_nxt = phi_pkg::ST_IDLE;
        end else begin
          state_nxt = phi_pkg::ST_SCAN;
        end
      end
      phi_pkg::ST_SCAN: begin
        if (hit) begin
          state_nxt = phi_pkg::ST_DIV;
        end else if (!rv_r && idx_r >= cnt_r) begin
          state_nxt = phi_pkg::ST_IDLE;
        end
      end
      phi_pkg::ST_DIV:  state_nxt = div_done ? phi_pkg::ST_MUL : phi_pkg::ST_DIV;
      phi_pkg::ST_MUL:  state_nxt = (mk_r == 2'd3) ? phi_pkg::ST_IDLE : phi_pkg::ST_MUL;
      default:          state_nxt = phi_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = full ? oldest_r : slot_f(oldest_r, cnt_r);
    mem_raddr = oldest_r;
    div_start = 1'b0;
    busy      = (state_r != phi_pkg::ST_IDLE);
    case (state_r)
      phi_pkg::ST_PWR:  mem_we = 1'b1;
      phi_pkg::ST_QB:   mem_raddr = slot_f(oldest_r, cnt_r - CW'(1));
      phi_pkg::ST_SCAN: begin
        mem_raddr = slot_f(oldest_r, idx_r);
        div_start = hit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= phi_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= phi_pkg::WINDOW_RST;
      oldest_r    <= '0;
      cnt_r       <= '0;
      rv_r        <= 1'b0;
      mk_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        win_r <= cfg_window_ms;
      end
      case (state_r)
        phi_pkg::ST_IDLE: begin
          if (start) begin
            in_r.x     <= in_pos_x;
            in_r.y     <= in_pos_y;
            in_r.hdg   <= in_heading;
            in_r.stamp <= in_time_ms;
          end
        end
        phi_pkg::ST_PWR: begin
          if (full) begin
            oldest_r <= slot_f(oldest_r, CW'(1));
          end else begin
            cnt_r <= cnt_r + CW'(1);
          end
        end
        phi_pkg::ST_PCMP: begin
          if (drop) begin
            oldest_r <= slot_f(oldest_r, CW'(1));
            cnt_r    <= cnt_r - CW'(1);
          end
        end
        phi_pkg::ST_QA: begin
          if (cnt_r == '0) begin
            out_valid_r <= 1'b1;
            out_x_r     <= '0;
            out_y_r     <= '0;
            out_h_r     <= '0;
            out_t_r     <= in_r.stamp;
            out_src_r   <= phi_pkg::SRC_EMPTY;
          end
        end
        phi_pkg::ST_QB: a_r <= rd;
        phi_pkg::ST_QC: begin
          b_r    <= rd;
          prev_r <= a_r;
          idx_r  <= CW'(1);
          rv_r   <= 1'b0;
          if (in_r.stamp <= a_r.stamp) begin
            out_valid_r <= 1'b1;
            out_x_r     <= a_r.x;
            out_y_r     <= a_r.y;
            out_h_r     <= a_r.hdg;
            out_t_r     <= a_r.stamp;
            out_src_r   <= phi_pkg::SRC_OLDEST;
          end else if (in_r.stamp >= rd.stamp) begin
            out_valid_r <= 1'b1;
            out_x_r     <= rd.x;
            out_y_r     <= rd.y;
            out_h_r     <= rd.hdg;
            out_t_r     <= rd.stamp;
            out_src_r   <= phi_pkg::SRC_NEWEST;
          end
        end
        phi_pkg::ST_SCAN: begin
          if (idx_r < cnt_r) begin
            idx_r <= idx_r + CW'(1);
            rv_r  <= 1'b1;
          end else begin
            rv_r <= 1'b0;
          end
          if (hit) begin
            q_r <= rd;
          end else if (rv_r) begin
            prev_r <= rd;
          end else if (idx_r >= cnt_r) begin
            // no bracketing entry: fall back to newest
            out_valid_r <= 1'b1;
            out_x_r     <= b_r.x;
            out_y_r     <= b_r.y;
            out_h_r     <= b_r.hdg;
            out_t_r     <= b_r.stamp;
            out_src_r   <= phi_pkg::SRC_NEWEST;
          end
        end
        phi_pkg::ST_DIV: begin
          alpha_r <= div_quot;
          mk_r    <= '0;
        end
        phi_pkg::ST_MUL: begin
          // one shared multiplier: x, y, heading; each sum adds the product held in prod_r
          prod_r <= $signed({1'b0, alpha_r}) * mul_op;
          mk_r   <= mk_r + 2'd1;
          case (mk_r)
            2'd1: out_x_r <= prev_r.x + prod_r[phi_pkg::FRAC_W +: phi_pkg::POS_W];
            2'd2: out_y_r <= prev_r.y + prod_r[phi_pkg::FRAC_W +: phi_pkg::POS_W];
            2'd3: begin
              out_h_r     <= prev_r.hdg + prod_r[phi_pkg::FRAC_W +: phi_pkg::ANG_W];
              out_t_r     <= in_r.stamp;
              out_src_r   <= phi_pkg::SRC_INTERP;
              out_valid_r <= 1'b1;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_x         = out_x_r;
  assign out_y         = out_y_r;
  assign out_heading   = out_h_r;
  assign out_used_time = out_t_r;
  assign out_source    = out_src_r;

  `PHI_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= DEPTH_C, "entry count above depth")
  `PHI_ASSERT_NOW(a_oldest_bound, 1'b1, oldest_r <= AW'(HISTORY_DEPTH - 1), "oldest index out of range")
  `PHI_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
  `PHI_ASSERT_NOW(a_result_from_work, out_valid, $past(busy), "result without transaction")

endmodule

[rtl/phi_mem.sv]
// Pose history storage: one write port, one registered read port.
// Depends on phi_pkg (entry_t).
module phi_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  phi_pkg::entry_t       wdata,
  input  logic [AW-1:0]         raddr,
  output phi_pkg::entry_t       rdata
);

  phi_pkg::entry_t mem [DEPTH];
  phi_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/phi_div.sv]
// Restoring divider for the Q1.16 interpolation fraction, one bit per cycle.
// Depends on phi_pkg (widths). Requires num <= den.
module phi_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [phi_pkg::TIME_W-1:0]    num,
  input  logic [phi_pkg::TIME_W-1:0]    den,
  output logic                          done,
  output logic [phi_pkg::ALPHA_W-1:0]   quot
);

  localparam int unsigned RW = phi_pkg::TIME_W + 2;

  logic [RW-1:0]                  rem_r;
  logic [phi_pkg::TIME_W-1:0]     den_r;
  logic [phi_pkg::ALPHA_W-1:0]    quot_r;
  logic [4:0]                     cnt_r;
  logic                           run_r;
  logic                           done_r;
  logic                           ge;
  logic [RW-1:0]                  rem_sub;
  logic [RW-1:0]                  rem_nxt;

  always_comb begin
    ge      = rem_r >= {2'b00, den_r};
    rem_sub = ge ? (rem_r - {2'b00, den_r}) : rem_r;
    rem_nxt = {rem_sub[RW-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r <= {2'b00, num};
        den_r <= den;
        cnt_r <= 5'(phi_pkg::ALPHA_W);
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r  <= rem_nxt;
        quot_r <= {quot_r[phi_pkg::ALPHA_W-2:0], ge};
        cnt_r  <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

[tb/tb.sv]
// Self-checking bench for the pose history interpolator: pushes and time queries
// checked against an in-bench ring-history predictor. Depends on phi_pkg and the RTL.
`timescale 1ns / 100ps

module tb;

  localparam int DEPTH = 64;
  localparam int DRAIN_CYCLES = 200;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic signed [phi_pkg::POS_W-1:0]  x;
    logic signed [phi_pkg::POS_W-1:0]  y;
    logic signed [phi_pkg::ANG_W-1:0]  hdg;
    logic        [phi_pkg::TIME_W-1:0] stamp;
    phi_pkg::src_t                     src;
  } pose_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_opcode = phi_pkg::OP_PUSH;
  logic signed [phi_pkg::POS_W-1:0] in_pos_x = '0;
  logic signed [phi_pkg::POS_W-1:0] in_pos_y = '0;
  logic signed [phi_pkg::ANG_W-1:0] in_heading = '0;
  logic [phi_pkg::TIME_W-1:0] in_time_ms = '0;
  logic cfg_we = 1'b0;
  logic [phi_pkg::WIN_W-1:0] cfg_window_ms = '0;
  logic out_valid;
  logic signed [phi_pkg::POS_W-1:0] out_x, out_y;
  logic signed [phi_pkg::ANG_W-1:0] out_heading;
  logic [phi_pkg::TIME_W-1:0] out_used_time;
  logic [1:0] out_source;

  pose_history_interpolator dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // predictor state
  logic signed [phi_pkg::POS_W-1:0]  hist_x [DEPTH];
  logic signed [phi_pkg::POS_W-1:0]  hist_y [DEPTH];
  logic signed [phi_pkg::ANG_W-1:0]  hist_h [DEPTH];
  logic        [phi_pkg::TIME_W-1:0] hist_t [DEPTH];
  int unsigned head_idx = 0;
  int unsigned fill = 0;
  logic [phi_pkg::WIN_W-1:0] window = phi_pkg::WINDOW_RST;

  pose_t expected_poses[$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int idle_cycles = 0;
  int src_seen[4];
  logic [phi_pkg::TIME_W-1:0] clock_ms = '0;

  function automatic int unsigned ring(int unsigned k);
    return (head_idx + k) % DEPTH;
  endfunction

  function automatic longint floor16(longint p);
    return p >>> 16;
  endfunction

  function automatic void record_push(logic signed [phi_pkg::POS_W-1:0] x,
                                      logic signed [phi_pkg::POS_W-1:0] y,
                                      logic signed [phi_pkg::ANG_W-1:0] h,
                                      logic [phi_pkg::TIME_W-1:0] t);
    int unsigned s;
    longint span;
    if (fill >= DEPTH) begin
      s = head_idx;
      head_idx = (head_idx + 1) % DEPTH;
    end else begin
      s = ring(fill);
      fill++;
    end
    hist_x[s] = x; hist_y[s] = y; hist_h[s] = h; hist_t[s] = t;
    while (fill > 2) begin
      span = longint'({24'd0, hist_t[ring(fill - 1)]}) - longint'({24'd0, hist_t[ring(0)]});
      if (span <= longint'({44'd0, window})) break;
      head_idx = (head_idx + 1) % DEPTH;
      fill--;
    end
  endfunction

  function automatic pose_t pose_at(logic [phi_pkg::TIME_W-1:0] tq);
    pose_t r;
    int unsigned a, b, p, q;
    longint dt, num, alpha, dh;
    logic signed [phi_pkg::ANG_W-1:0] dhw;
    if (fill == 0) begin
      r.x = '0; r.y = '0; r.hdg = '0; r.stamp = tq; r.src = phi_pkg::SRC_EMPTY;
      return r;
    end
    a = ring(0);
    b = ring(fill - 1);
    if (tq <= hist_t[a]) begin
      r.x = hist_x[a]; r.y = hist_y[a]; r.hdg = hist_h[a]; r.stamp = hist_t[a];
      r.src = phi_pkg::SRC_OLDEST;
      return r;
    end
    r.x = hist_x[b]; r.y = hist_y[b]; r.hdg = hist_h[b]; r.stamp = hist_t[b];
    r.src = phi_pkg::SRC_NEWEST;
    if (tq >= hist_t[b]) return r;
    for (int unsigned i = 1; i < fill; i++) begin
      p = ring(i - 1);
      q = ring(i);
      if (tq <= hist_t[q]) begin
        dt = longint'({24'd0, hist_t[q]}) - longint'({24'd0, hist_t[p]});
        num = longint'({24'd0, tq}) - longint'({24'd0, hist_t[p]});
        alpha = 0;
        if (dt > 0 && num > 0) begin
          alpha = (num <<< 16) / dt;
          if (alpha > 65536) alpha = 65536;
        end
        r.x = phi_pkg::POS_W'(longint'(hist_x[p]) +
                              floor16(alpha * (longint'(hist_x[q]) - hist_x[p])));
        r.y = phi_pkg::POS_W'(longint'(hist_y[p]) +
                              floor16(alpha * (longint'(hist_y[q]) - hist_y[p])));
        dhw = phi_pkg::ANG_W'(longint'(hist_h[q]) - longint'(hist_h[p]));
        dh = dhw;
        r.hdg = phi_pkg::ANG_W'(longint'(hist_h[p]) + floor16(alpha * dh));
        r.stamp = tq;
        r.src = phi_pkg::SRC_INTERP;
        return r;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("[%0t] mismatch on %s: got %0h expected %0h", $time, what, got, want);
  endtask

  // result checker
  always @(posedge clk) begin
    pose_t e;
    if (rst_n && out_valid) begin
      if (expected_poses.size() == 0) begin
        errors++;
        $display("[%0t] result transaction with nothing expected", $time);
      end else begin
        e = expected_poses[0];
        expected_poses.delete(0);
        n_results++;
        src_seen[e.src]++;
        if (out_x !== e.x) report_mismatch("out_x", out_x, e.x);
        if (out_y !== e.y) report_mismatch("out_y", out_y, e.y);
        if (out_heading !== e.hdg) report_mismatch("out_heading", out_heading, e.hdg);
        if (out_used_time !== e.stamp) report_mismatch("out_used_time", out_used_time, e.stamp);
        if (out_source !== e.src) report_mismatch("out_source", out_source, e.src);
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("pose_history_interpolator regression: fail");
      $finish;
    end
  end

  task automatic send_item(logic op, logic signed [phi_pkg::POS_W-1:0] x,
                           logic signed [phi_pkg::POS_W-1:0] y,
                           logic signed [phi_pkg::ANG_W-1:0] h,
                           logic [phi_pkg::TIME_W-1:0] t);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    // start was dropped at the last accept edge; the block is busy for that cycle anyway
    @(posedge clk);
    repeat (gap) @(posedge clk);
    start <= 1'b1;
    in_opcode <= op; in_pos_x <= x; in_pos_y <= y; in_heading <= h; in_time_ms <= t;
    do @(posedge clk); while (busy);
    // accepted at this edge
    if (op == phi_pkg::OP_PUSH) record_push(x, y, h, t);
    else expected_poses.insert(expected_poses.size(), pose_at(t));
    n_items++;
    start <= 1'b0;
  endtask

  task automatic push_pose(logic [phi_pkg::TIME_W-1:0] t);
    send_item(phi_pkg::OP_PUSH, phi_pkg::POS_W'($urandom), phi_pkg::POS_W'($urandom),
              phi_pkg::ANG_W'($urandom), t);
  endtask

  task automatic query_at(logic [phi_pkg::TIME_W-1:0] t);
    send_item(phi_pkg::OP_QUERY, phi_pkg::POS_W'($urandom), phi_pkg::POS_W'($urandom),
              phi_pkg::ANG_W'($urandom), t);
  endtask

  task automatic settle();
    int n;
    n = 0;
    while (expected_poses.size() != 0 && n < 20000) begin
      @(posedge clk);
      n++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_window(logic [phi_pkg::WIN_W-1:0] w);
    settle();
    cfg_we <= 1'b1;
    cfg_window_ms <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    window = w;
  endtask

  task automatic test_directed();
    query_at(40'd123);                               // empty history
    send_item(phi_pkg::OP_PUSH, 24'sh7FFFFF, 24'sh800000, 16'sh7FFF, 40'd1000);
    query_at(40'd0);
    query_at(40'd5000);
    send_item(phi_pkg::OP_PUSH, 24'sh800000, 24'sh7FFFFF, 16'sh8000, 40'd2000);
    query_at(40'd1000);                              // at oldest
    query_at(40'd2000);                              // at newest
    query_at(40'd1500);                              // extremes interpolated
    send_item(phi_pkg::OP_PUSH, 24'sh000100, -24'sh000100, 16'sh0000, 40'd2000);
    query_at(40'd1999);                              // zero interval behind
    send_item(phi_pkg::OP_PUSH, 24'sh000000, 24'sh000001, 16'sh8000, 40'd2003);
    query_at(40'd2001);                              // half-turn heading step
    send_item(phi_pkg::OP_PUSH, 24'sh000010, 24'sh000010, 16'sh1000, 40'd1500); // time goes back
    query_at(40'd1800);
    query_at(40'd1999);
    send_item(phi_pkg::OP_PUSH, 24'sh0, 24'sh0, 16'sh0, 40'hFF_FFFF_FFFF);      // drops far behind
    query_at(40'hFF_FFFF_FFFE);
    query_at(40'hFF_FFFF_FFFF);
    send_item(phi_pkg::OP_PUSH, 24'sh1, 24'sh1, 16'sh1, 40'd0);                 // negative span
    query_at(40'h80_0000_0000);
  endtask

  // ordered pose streams at ~10 ms spacing, mostly queries inside the span
  task automatic test_random_stream(int count);
    logic [phi_pkg::TIME_W-1:0] t;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 19))
        0: push_pose(phi_pkg::TIME_W'({$urandom, $urandom}));        // noise
        1, 2, 3, 4, 5, 6, 7: begin
          clock_ms = clock_ms + $urandom_range(0, 20);
          push_pose(clock_ms);
        end
        8: query_at(phi_pkg::TIME_W'({$urandom, $urandom}));
        default: begin
          t = clock_ms - $urandom_range(0, 600);
          query_at(t);
        end
      endcase
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    set_window(20'd0);
    clock_ms = 40'd10_000;
    test_random_stream(250);
    set_window(20'hFFFFF);
    clock_ms = 40'hFF_FF00_0000;
    test_random_stream(600);
    set_window(20'd300);
    clock_ms = 40'd50_000;
    test_random_stream(500);
    set_window(20'd5000);
    test_random_stream(550);
    settle();
    $display("items sent: %0d, results checked: %0d", n_items, n_results);
    $display("sources interp/oldest/newest/empty: %0d/%0d/%0d/%0d",
             src_seen[0], src_seen[1], src_seen[2], src_seen[3]);
    if (errors == 0 && expected_poses.size() == 0) begin
      $display("pose_history_interpolator regression: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_poses.size());
      $display("pose_history_interpolator regression: fail");
    end
    $finish;
  end

endmodule

[pose_history_interpolator.f]
+incdir+rtl
rtl/phi_pkg.sv
rtl/phi_mem.sv
rtl/phi_div.sv
rtl/pose_history_interpolator.sv
tb/tb.sv
